@@ sv/hull_corner_detector_core_macros.svh @@
// ============================================================================
// Hull corner detector assertion macros
// Shared concurrent assertion forms for the hull corner detector checkers.
// ============================================================================
`ifndef HULL_CORNER_DETECTOR_CORE_MACROS_SVH
`define HULL_CORNER_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hcd_pkg.sv @@
// ============================================================================
// Hull corner detector package
// Types, register codes, reset values and the arctangent table.
// ============================================================================
`timescale 1ns / 1ps

package hcd_pkg;

    // Register field widths.
    localparam int ANGLE_THR_BITS = 16;
    localparam int DIST_THR_BITS  = 13;
    localparam int LIMIT_BITS     = 8;
    localparam int NUMBER_BITS    = 8;

    // Configuration port geometry.
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ANGLE_THR   = 2'd0;
    localparam logic [1:0] REG_DIST_THR    = 2'd1;
    localparam logic [1:0] REG_CORNER_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [ANGLE_THR_BITS-1:0] ANGLE_THR_RESET   = 16'd4096;
    localparam logic [DIST_THR_BITS-1:0]  DIST_THR_RESET    = 13'd10;
    localparam logic [LIMIT_BITS-1:0]     CORNER_LIMIT_RESET = 8'd4;

    // CORDIC iteration count and operand pre-scaling.
    localparam int CORDIC_STEPS     = 28;
    localparam int CORDIC_PRE_SHIFT = 32;
    localparam int ITER_BITS        = $clog2(CORDIC_STEPS);

    // Configuration register set.
    typedef struct packed {
        logic [ANGLE_THR_BITS-1:0] angle_thr;
        logic [DIST_THR_BITS-1:0]  dist_thr;
        logic [LIMIT_BITS-1:0]     corner_limit;
    } t_cfg;

    // Whether the previous edge had a usable direction.
    typedef enum logic [1:0] {
        DIR_NONE    = 2'd0,
        DIR_VALID   = 2'd1,
        DIR_INVALID = 2'd2
    } t_dir_state;

    // atan(2^-i) in units of pi/2^30, rounded to nearest.
    function automatic logic signed [31:0] f_atan(input logic [ITER_BITS-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd268435456;
            5'd1:    v = 32'sd158466703;
            5'd2:    v = 32'sd83729454;
            5'd3:    v = 32'sd42502378;
            5'd4:    v = 32'sd21333666;
            5'd5:    v = 32'sd10677233;
            5'd6:    v = 32'sd5339919;
            5'd7:    v = 32'sd2670123;
            5'd8:    v = 32'sd1335082;
            5'd9:    v = 32'sd667543;
            5'd10:   v = 32'sd333772;
            5'd11:   v = 32'sd166886;
            5'd12:   v = 32'sd83443;
            5'd13:   v = 32'sd41722;
            5'd14:   v = 32'sd20861;
            5'd15:   v = 32'sd10430;
            5'd16:   v = 32'sd5215;
            5'd17:   v = 32'sd2608;
            5'd18:   v = 32'sd1304;
            5'd19:   v = 32'sd652;
            5'd20:   v = 32'sd326;
            5'd21:   v = 32'sd163;
            5'd22:   v = 32'sd81;
            5'd23:   v = 32'sd41;
            5'd24:   v = 32'sd20;
            5'd25:   v = 32'sd10;
            5'd26:   v = 32'sd5;
            5'd27:   v = 32'sd3;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/hcd_apb_regs.sv @@
// ============================================================================
// Hull corner detector configuration registers
// APB-style register file holding the angle, distance and limit settings.
// ============================================================================
`timescale 1ns / 1ps

module hcd_apb_regs
    import hcd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_thr    <= ANGLE_THR_RESET;
            r_cfg.dist_thr     <= DIST_THR_RESET;
            r_cfg.corner_limit <= CORNER_LIMIT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_ANGLE_THR:    r_cfg.angle_thr    <= pwdata[ANGLE_THR_BITS-1:0];
                REG_DIST_THR:     r_cfg.dist_thr     <= pwdata[DIST_THR_BITS-1:0];
                REG_CORNER_LIMIT: r_cfg.corner_limit <= pwdata[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data, zero extended; unused addresses read as zero.
    always_comb begin
        case (w_idx)
            REG_ANGLE_THR:    prdata = CFG_DATA_BITS'(r_cfg.angle_thr);
            REG_DIST_THR:     prdata = CFG_DATA_BITS'(r_cfg.dist_thr);
            REG_CORNER_LIMIT: prdata = CFG_DATA_BITS'(r_cfg.corner_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ sv/hcd_cordic.sv @@
// ============================================================================
// Hull corner detector arctangent unit
// Iterative vectoring CORDIC giving atan(ax/ay) folded to [0, pi/2].
// ============================================================================
`timescale 1ns / 1ps

module hcd_cordic
    import hcd_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    output logic                  o_busy,
    output logic [ANGLE_BITS-1:0] o_mag
);

    // Datapath width: pre-scaled operand plus CORDIC gain headroom and sign.
    localparam int W = COORD_BITS + CORDIC_PRE_SHIFT + 3;
    localparam int SH = 31 - ANGLE_BITS;
    localparam logic [31:0] RND    = 32'd1 << (30 - ANGLE_BITS);
    localparam logic [31:0] ZMAX   = 32'd1 << 29;
    localparam logic [31:0] HALF32 = 32'd1 << (ANGLE_BITS - 2);
    localparam logic [ITER_BITS-1:0] LAST_ITER = ITER_BITS'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ITER  = 3'b010,
        C_ROUND = 3'b100
    } t_cordic_state;

    t_cordic_state          r_state;
    t_cordic_state          n_state;
    logic [ITER_BITS-1:0]   r_iter;
    logic [W-1:0]           r_x;
    logic signed [W-1:0]    r_y;
    logic signed [31:0]     r_z;
    logic [ANGLE_BITS-1:0]  r_mag;

    logic                   w_yneg;
    logic [W-1:0]           w_yabs;
    logic [W-1:0]           w_xs;
    logic [W-1:0]           w_ysh;
    logic [31:0]            w_zc;
    logic [31:0]            w_zr;
    logic [31:0]            w_ms;
    logic [31:0]            w_mag;

    assign o_busy = (r_state != C_IDLE);
    assign o_mag  = r_mag;

    // One micro-rotation: x grows by |y| >> i, y moves toward zero by x >> i.
    assign w_yneg = r_y[W-1];
    assign w_yabs = w_yneg ? (~r_y + W'(1)) : r_y;
    assign w_xs   = r_x >> r_iter;
    assign w_ysh  = w_yabs >> r_iter;

    // Final angle: clamp to [0, pi/2] in table units, round half up.
    assign w_zc  = r_z[31] ? 32'd0 : ((r_z > $signed(ZMAX)) ? ZMAX : r_z);
    assign w_zr  = w_zc + RND;
    assign w_ms  = w_zr >> SH;
    assign w_mag = (w_ms > HALF32) ? HALF32 : w_ms;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_start && (i_ay != '0) && (i_ax != '0)) begin
                    n_state = C_ITER;
                end
            end
            C_ITER: begin
                if (r_iter == LAST_ITER) begin
                    n_state = C_ROUND;
                end
            end
            C_ROUND: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Rotation registers and result; axis-aligned edges resolve at start.
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_iter <= '0;
            r_x    <= W'({i_ay, {CORDIC_PRE_SHIFT{1'b0}}});
            r_y    <= W'({i_ax, {CORDIC_PRE_SHIFT{1'b0}}});
            r_z    <= '0;
            if (i_ay == '0) begin
                r_mag <= HALF32[ANGLE_BITS-1:0];
            end else if (i_ax == '0) begin
                r_mag <= '0;
            end
        end else if (r_state == C_ITER) begin
            r_iter <= r_iter + ITER_BITS'(1);
            r_x    <= r_x + w_ysh;
            if (!w_yneg) begin
                r_y <= r_y - $signed(w_xs);
                r_z <= r_z + f_atan(r_iter);
            end else begin
                r_y <= r_y + $signed(w_xs);
                r_z <= r_z - f_atan(r_iter);
            end
        end else if (r_state == C_ROUND) begin
            r_mag <= w_mag[ANGLE_BITS-1:0];
        end
    end

endmodule

@@ sv/hcd_dist.sv @@
// ============================================================================
// Hull corner detector distance test
// Squared distance against the squared threshold on one shared multiplier.
// ============================================================================
`timescale 1ns / 1ps

module hcd_dist
    import hcd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [COORD_BITS-1:0]    i_ex,
    input  logic [COORD_BITS-1:0]    i_ey,
    input  logic [DIST_THR_BITS-1:0] i_thr,
    output logic                     o_busy,
    output logic                     o_far
);

    localparam int MW = (COORD_BITS > DIST_THR_BITS) ? COORD_BITS : DIST_THR_BITS;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 1;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_SQY  = 4'b0010,
        D_SQT  = 4'b0100,
        D_CMP  = 4'b1000
    } t_dist_state;

    t_dist_state    r_state;
    t_dist_state    n_state;
    logic [PW-1:0]  r_prod;
    logic [AW-1:0]  r_acc;
    logic           r_far;
    logic [MW-1:0]  w_op;

    assign o_busy = (r_state != D_IDLE);
    assign o_far  = r_far;

    // Multiplier operand: ex at start, then ey, then the threshold.
    always_comb begin
        unique case (r_state)
            D_IDLE:  w_op = MW'(i_ex);
            D_SQY:   w_op = MW'(i_ey);
            default: w_op = MW'(i_thr);
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = D_SQY;
                end
            end
            D_SQY:   n_state = D_SQT;
            D_SQT:   n_state = D_CMP;
            D_CMP:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Product register, running sum and final compare.
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_prod <= w_op * w_op;
        end else if (r_state == D_SQY) begin
            r_prod <= w_op * w_op;
            r_acc  <= AW'(r_prod);
        end else if (r_state == D_SQT) begin
            r_prod <= w_op * w_op;
            r_acc  <= r_acc + AW'(r_prod);
        end else if (r_state == D_CMP) begin
            r_far <= (r_acc > AW'(r_prod));
        end
    end

endmodule

@@ sv/hull_corner_detector_core.sv @@
// ============================================================================
// Hull corner detector core
// Finds corners among the ordered points of a convex hull.
// ============================================================================
// Points of one hull arrive in order, the hull's last point first with
// i_first set; that item only seeds the previous point. A seed item, an item
// of an abandoned hull and a repeated point leave the block idle and ready
// at once. Any other point keeps it busy from acceptance through the
// 28-iteration CORDIC loop that finds the edge direction, its rounding step,
// and the calculate and decide states of the sequencer. Horizontal and
// vertical edges skip the loop; the distance test's ey, threshold and compare
// states on its shared multiplier, which runs alongside the CORDIC, then set
// the wait, plus the calculate and decide states. A result waits in an
// output register, and the next point is accepted meanwhile; the block holds
// in its decision state only when a new corner is ready while the previous
// one has not been taken. Configuration is to be written through the
// APB-style port while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module hull_corner_detector_core
    import hcd_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // Point input.
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_first,
    input  logic [COORD_BITS-1:0]    i_point_x,
    input  logic [COORD_BITS-1:0]    i_point_y,
    // Corner output.
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [COORD_BITS-1:0]    o_corner_x,
    output logic [COORD_BITS-1:0]    o_corner_y,
    output logic [NUMBER_BITS-1:0]   o_corner_number,
    output logic                     o_too_many
);

    localparam int DW = (ANGLE_BITS + 1 > ANGLE_THR_BITS) ? ANGLE_BITS + 1 : ANGLE_THR_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_CALC   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_cfg                      w_cfg;
    t_state                    r_state;
    t_state                    n_state;

    // Hull tracking state.
    logic [COORD_BITS-1:0]     r_last_x;
    logic [COORD_BITS-1:0]     r_last_y;
    logic signed [ANGLE_BITS-1:0] r_last_dir;
    t_dir_state                r_dir_state;
    logic [COORD_BITS-1:0]     r_kept_x;
    logic [COORD_BITS-1:0]     r_kept_y;
    logic                      r_have;
    logic [LIMIT_BITS-1:0]     r_count;
    logic                      r_abandon;

    // Current point while its edge is worked on.
    logic [COORD_BITS-1:0]     r_px;
    logic [COORD_BITS-1:0]     r_py;
    logic                      r_neg;

    // Output register.
    logic                      r_ovalid;
    logic [COORD_BITS-1:0]     r_ox;
    logic [COORD_BITS-1:0]     r_oy;
    logic [NUMBER_BITS-1:0]    r_onum;
    logic                      r_otoo;

    logic                      w_accept;
    logic                      w_same;
    logic                      w_go;
    logic [COORD_BITS-1:0]     w_ax;
    logic [COORD_BITS-1:0]     w_ay;
    logic                      w_neg;
    logic [COORD_BITS-1:0]     w_ex;
    logic [COORD_BITS-1:0]     w_ey;
    logic                      w_cordic_busy;
    logic [ANGLE_BITS-1:0]     w_mag;
    logic                      w_dist_busy;
    logic                      w_dist_far;
    logic signed [ANGLE_BITS-1:0] w_dir;
    logic signed [ANGLE_BITS:0]   w_diff;
    logic [ANGLE_BITS:0]       w_delta;
    logic                      w_turn;
    logic                      w_hit;
    logic                      w_over;
    logic                      w_slot;
    logic                      w_commit;

    hcd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input handshake and edge vector of the arriving point.
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_same   = (i_point_x == r_last_x) && (i_point_y == r_last_y);
    assign w_go     = w_accept && !i_first && !r_abandon && !w_same;
    assign w_ax     = (r_last_x >= i_point_x) ? (r_last_x - i_point_x) : (i_point_x - r_last_x);
    assign w_ay     = (r_last_y >= i_point_y) ? (r_last_y - i_point_y) : (i_point_y - r_last_y);
    assign w_neg    = (r_last_x < i_point_x) != (r_last_y < i_point_y);

    // Offset of the previous point from the last kept corner.
    assign w_ex = (r_last_x >= r_kept_x) ? (r_last_x - r_kept_x) : (r_kept_x - r_last_x);
    assign w_ey = (r_last_y >= r_kept_y) ? (r_last_y - r_kept_y) : (r_kept_y - r_last_y);

    hcd_cordic #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .o_busy  (w_cordic_busy),
        .o_mag   (w_mag)
    );

    hcd_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go),
        .i_ex    (w_ex),
        .i_ey    (w_ey),
        .i_thr   (w_cfg.dist_thr),
        .o_busy  (w_dist_busy),
        .o_far   (w_dist_far)
    );

    // Corner decision from the signed direction and the distance test.
    assign w_dir    = r_neg ? $signed(~w_mag + ANGLE_BITS'(1)) : $signed(w_mag);
    assign w_diff   = {w_dir[ANGLE_BITS-1], w_dir} - {r_last_dir[ANGLE_BITS-1], r_last_dir};
    assign w_delta  = w_diff[ANGLE_BITS] ? (~w_diff + (ANGLE_BITS+1)'(1)) : w_diff;
    assign w_turn   = (DW'(w_delta) > DW'(w_cfg.angle_thr));
    assign w_hit    = (r_dir_state == DIR_VALID) && w_turn && (!r_have || w_dist_far);
    assign w_over   = w_hit && (r_count >= w_cfg.corner_limit);
    assign w_slot   = !r_ovalid || i_ready;
    assign w_commit = (r_state == S_DECIDE) && (!w_hit || w_slot);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (!w_cordic_busy && !w_dist_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and hull tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_dir  <= '0;
            r_dir_state <= DIR_NONE;
            r_kept_x    <= '0;
            r_kept_y    <= '0;
            r_have      <= 1'b0;
            r_count     <= '0;
            r_abandon   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // A seed item restarts the hull; a repeated point voids the direction.
            if (w_accept && i_first) begin
                r_last_x    <= i_point_x;
                r_last_y    <= i_point_y;
                r_last_dir  <= '0;
                r_dir_state <= DIR_NONE;
                r_have      <= 1'b0;
                r_count     <= '0;
                r_abandon   <= 1'b0;
            end else if (w_accept && !r_abandon && w_same) begin
                r_last_dir  <= '0;
                r_dir_state <= DIR_INVALID;
            end

            // End of a full edge: overflow abandons the hull, else advance.
            if (w_commit) begin
                if (w_over) begin
                    r_abandon <= 1'b1;
                end else begin
                    if (w_hit) begin
                        r_kept_x <= r_last_x;
                        r_kept_y <= r_last_y;
                        r_have   <= 1'b1;
                        r_count  <= r_count + LIMIT_BITS'(1);
                    end
                    r_last_x    <= r_px;
                    r_last_y    <= r_py;
                    r_last_dir  <= w_dir;
                    r_dir_state <= DIR_VALID;
                end
            end

            // Output valid: set by a new result, cleared when the item is taken.
            if (w_commit && w_hit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Point capture and output payload.
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_neg <= w_neg;
        end
        if (w_commit && w_hit) begin
            r_ox   <= w_over ? '0 : r_last_x;
            r_oy   <= w_over ? '0 : r_last_y;
            r_onum <= NUMBER_BITS'(r_count);
            r_otoo <= w_over;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_corner_x      = r_ox;
    assign o_corner_y      = r_oy;
    assign o_corner_number = r_onum;
    assign o_too_many      = r_otoo;

endmodule

@@ sv/hcd_checker.sv @@
// ============================================================================
// Hull corner detector port checker
// Concurrent assertions on the top-level ports, bound to the core.
// ============================================================================
`timescale 1ns / 1ps
`include "hull_corner_detector_core_macros.svh"

module hcd_checker
    import hcd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   i_first,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [COORD_BITS-1:0]  o_corner_x,
    input logic [COORD_BITS-1:0]  o_corner_y,
    input logic [NUMBER_BITS-1:0] o_corner_number,
    input logic                   o_too_many
);

    // A stalled result item holds its payload.
    `HCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_corner_x) && $stable(o_corner_y) && $stable(o_corner_number) && $stable(o_too_many), "stalled result item changed")

    // A seed item does not occupy the block.
    `HCD_ASSERT_NEXT(a_seed_ready, i_clk, i_rst_n, i_valid && o_ready && i_first, o_ready, "block busy after a seed item")

    // A result never appears in the cycle right after an item is accepted.
    `HCD_ASSERT_IMPL(a_no_early, i_clk, i_rst_n, $rose(o_valid), !$past(i_valid && o_ready), "result right after acceptance")

    // An overflow item carries no coordinates.
    `HCD_ASSERT_IMPL(a_over_zero, i_clk, i_rst_n, o_valid && o_too_many, (o_corner_x == '0) && (o_corner_y == '0), "overflow item with coordinates")

endmodule

bind hull_corner_detector_core hcd_checker #(
    .COORD_BITS (COORD_BITS)
) u_hcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_first         (i_first),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_corner_x      (o_corner_x),
    .o_corner_y      (o_corner_y),
    .o_corner_number (o_corner_number),
    .o_too_many      (o_too_many)
);

@@ bench/hull_corner_scoreboard.sv @@
// ----------------------------------------------------------------------------
// Hull corner scoreboard
// Predicts the corners of each hull from the accepted points and checks the
// corner items that the block returns, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hull_corner_check_pkg;
    import hcd_pkg::*;

    localparam int COORD_W    = 12;
    localparam int DIR_W      = 16;
    localparam int ARC_STEPS  = 28;
    localparam int MAX_REPORT = 10;

    // atan(2^-i) in units of pi/2^30.
    localparam longint ARC_STEP_ANGLE [0:ARC_STEPS-1] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
        5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3
    };

    // One corner item as the block should return it.
    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [NUMBER_BITS-1:0] number;
        logic                   too_many;
    } corner_item;

    // Edge direction in units of pi/2^(DIR_W-1), folded to +-pi/2.
    // The caller never passes a zero-length edge.
    function automatic int edge_angle(int dx, int dy);
        longint ax, ay, cx, cy, acc, xs, ys;
        int     mag, i;
        int     quarter;
        quarter = 1 << (DIR_W - 2);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ay == 0) begin
            mag = quarter;
        end else if (ax == 0) begin
            mag = 0;
        end else begin
            // Vectoring rotation; shifts of a negative residue round toward zero.
            cx  = ay <<< 32;
            cy  = ax <<< 32;
            acc = 0;
            for (i = 0; i < ARC_STEPS; i++) begin
                xs = cx >>> i;
                ys = (cy >= 0) ? (cy >>> i) : -((-cy) >>> i);
                if (cy >= 0) begin
                    cx  = cx + ys;
                    cy  = cy - xs;
                    acc = acc + ARC_STEP_ANGLE[i];
                end else begin
                    cx  = cx - ys;
                    cy  = cy + xs;
                    acc = acc - ARC_STEP_ANGLE[i];
                end
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 29)) acc = 64'sd1 <<< 29;
            mag = int'((acc + (64'sd1 <<< (30 - DIR_W))) >>> (31 - DIR_W));
            if (mag > quarter) mag = quarter;
        end
        return ((dx < 0) != (dy < 0)) ? -mag : mag;
    endfunction

    class hull_corner_scoreboard;
        // Register copies.
        int unsigned angle_thr;
        int unsigned dist_thr;
        int unsigned corner_limit;

        // Hull tracking state.
        int          last_x, last_y, last_dir;
        t_dir_state  dir_state;
        int          kept_x, kept_y;
        bit          have_corner;
        int unsigned corner_count;
        bit          abandoned;

        corner_item  corners_due[$];

        int unsigned errors;
        int unsigned points_seen, points_ignored, hulls_seen;
        int unsigned corners_checked, overflows_checked;

        function new();
            angle_thr    = 32'(ANGLE_THR_RESET);
            dist_thr     = 32'(DIST_THR_RESET);
            corner_limit = 32'(CORNER_LIMIT_RESET);
            last_x       = 0;
            last_y       = 0;
            last_dir     = 0;
            dir_state    = DIR_NONE;
            kept_x       = 0;
            kept_y       = 0;
            have_corner  = 1'b0;
            corner_count = 0;
            abandoned    = 1'b0;
        endfunction

        // Mirrors a register write; values are cut to the register width.
        function void write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_ANGLE_THR:    angle_thr    = 32'(value[ANGLE_THR_BITS-1:0]);
                REG_DIST_THR:     dist_thr     = 32'(value[DIST_THR_BITS-1:0]);
                REG_CORNER_LIMIT: corner_limit = 32'(value[LIMIT_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned useful_points();
            return points_seen - points_ignored;
        endfunction

        function int pending_count();
            return corners_due.size();
        endfunction

        // Advances the hull state by one accepted point and queues any corner.
        function void note_point(bit first, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            int         dx, dy, dir, diff, ex, ey, nx, ny;
            longint     d2, t2;
            t_dir_state edge_state;
            bit         far_enough;
            corner_item item;
            nx = int'(px);
            ny = int'(py);
            dir = 0;
            points_seen++;

            // A seed point restarts the hull.
            if (first) begin
                last_x       = nx;
                last_y       = ny;
                last_dir     = 0;
                dir_state    = DIR_NONE;
                have_corner  = 1'b0;
                corner_count = 0;
                abandoned    = 1'b0;
                hulls_seen++;
                return;
            end
            if (abandoned) begin
                points_ignored++;
                return;
            end

            dx = last_x - nx;
            dy = last_y - ny;
            if (dx == 0 && dy == 0) begin
                edge_state = DIR_INVALID;
            end else begin
                edge_state = DIR_VALID;
                dir = edge_angle(dx, dy);
            end

            // A corner needs two valid edges, a large turn and enough spacing.
            if (edge_state == DIR_VALID && dir_state == DIR_VALID) begin
                diff = dir - last_dir;
                if (diff < 0) diff = -diff;
                if (diff > angle_thr) begin
                    far_enough = 1'b1;
                    if (have_corner) begin
                        ex = last_x - kept_x;
                        ey = last_y - kept_y;
                        d2 = longint'(ex) * ex + longint'(ey) * ey;
                        t2 = longint'(dist_thr) * dist_thr;
                        far_enough = (d2 > t2);
                    end
                    if (far_enough) begin
                        if (corner_count >= corner_limit) begin
                            item.x        = '0;
                            item.y        = '0;
                            item.number   = corner_count[NUMBER_BITS-1:0];
                            item.too_many = 1'b1;
                            corners_due.push_back(item);
                            abandoned = 1'b1;
                            return;
                        end
                        item.x        = last_x[COORD_W-1:0];
                        item.y        = last_y[COORD_W-1:0];
                        item.number   = corner_count[NUMBER_BITS-1:0];
                        item.too_many = 1'b0;
                        corners_due.push_back(item);
                        kept_x       = last_x;
                        kept_y       = last_y;
                        have_corner  = 1'b1;
                        corner_count = (corner_count + 1) & 8'hFF;
                    end
                end
            end

            last_x    = nx;
            last_y    = ny;
            last_dir  = (edge_state == DIR_VALID) ? dir : 0;
            dir_state = edge_state;
        endfunction

        // Compares a returned corner item with the oldest one predicted.
        function void check_corner(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [NUMBER_BITS-1:0] number, logic too_many);
            corner_item want;
            if (corners_due.size() == 0) begin
                if (errors < MAX_REPORT)
                    $display("ERROR: unexpected corner x=%0d y=%0d number=%0d too_many=%0b",
                             x, y, number, too_many);
                errors++;
                return;
            end
            want = corners_due.pop_front();
            if (want.too_many) overflows_checked++;
            else corners_checked++;
            if (x !== want.x || y !== want.y || number !== want.number ||
                too_many !== want.too_many) begin
                if (errors < MAX_REPORT)
                    $display("ERROR: corner mismatch: expected x=%0d y=%0d number=%0d %s%0b, %s",
                             want.x, want.y, want.number, "too_many=", want.too_many,
                             $sformatf("got x=%0d y=%0d number=%0d too_many=%0b",
                                       x, y, number, too_many));
                errors++;
            end
        endfunction
    endclass

endpackage

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Hull corner detector core testbench
// Feeds hull point sequences under a series of register settings, with random
// idle cycles on both channels and one long output hold-off, and checks every
// corner item against a scoreboard that tracks the hull state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import hcd_pkg::*;
    import hull_corner_check_pkg::*;

    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 500;
    localparam int STEADY_PHASE  = 2;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel, penable, pwrite, pready;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata, prdata;
    logic                     i_valid, o_ready, i_first;
    logic [COORD_W-1:0]       i_point_x, i_point_y;
    logic                     o_valid, i_ready;
    logic [COORD_W-1:0]       o_corner_x, o_corner_y;
    logic [NUMBER_BITS-1:0]   o_corner_number;
    logic                     o_too_many;

    hull_corner_scoreboard sb;
    bit steady;
    bit held_off;
    int hold_left;
    int settings_used;

    hull_corner_detector_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first        (i_first),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_corner_x     (o_corner_x),
        .o_corner_y     (o_corner_y),
        .o_corner_number(o_corner_number),
        .o_too_many     (o_too_many)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Give up if the run hangs.
    initial begin
        #2000000;
        $display("FAIL hull_corner_detector_core");
        $finish;
    end

    // Receiver: random idling, one long hold-off, no idling in the steady phase.
    always @(negedge i_clk) begin
        if (i_rst_n && !held_off && sb.useful_points() >= HOLD_AT) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 20);
        end
    end

    // Both handshakes are observed on the values held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_corner(o_corner_x, o_corner_y, o_corner_number, o_too_many);
            if (i_valid && o_ready)
                sb.note_point(i_first, i_point_x, i_point_y);
        end
    end

    function automatic logic [COORD_W-1:0] fit_coord(int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'd4095;
        return v[COORD_W-1:0];
    endfunction

    // Offers one point item and returns at the edge that accepts it.
    task automatic send_point(bit first, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int gap;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            gap = $urandom_range(8, 1);
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_first   <= first;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Lets the block go idle: no item offered, nothing pending, then a settle time.
    task automatic drain_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write; unused upper data bits are sometimes filled with noise.
    task automatic write_register(logic [1:0] idx, int unsigned value);
        logic [CFG_DATA_BITS-1:0] data, mask;
        case (idx)
            REG_ANGLE_THR:    mask = (32'd1 << ANGLE_THR_BITS) - 1;
            REG_DIST_THR:     mask = (32'd1 << DIST_THR_BITS) - 1;
            default:          mask = (32'd1 << LIMIT_BITS) - 1;
        endcase
        data = value & mask;
        if ($urandom_range(1)) data = data | ($urandom() & ~mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A seeded walk of straight runs; turns between runs make the corners.
    task automatic send_hull();
        int x, y, sx, sy, segs, reps, kind;
        x = $urandom_range(4095);
        y = $urandom_range(4095);
        // Now and then the seed is left out and the walk continues the old hull.
        if ($urandom_range(99) < 92) send_point(1'b1, COORD_W'(x), COORD_W'(y));
        segs = $urandom_range(12, 2);
        repeat (segs) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                sx = 0;
                sy = 0;
            end else if (kind < 20) begin
                sx = int'($urandom_range(80)) - 40;
                sy = 0;
            end else if (kind < 32) begin
                sx = 0;
                sy = int'($urandom_range(80)) - 40;
            end else if (kind < 60) begin
                sx = int'($urandom_range(12)) - 6;
                sy = int'($urandom_range(12)) - 6;
            end else begin
                sx = int'($urandom_range(120)) - 60;
                sy = int'($urandom_range(120)) - 60;
            end
            reps = $urandom_range(5, 1);
            repeat (reps) begin
                if ($urandom_range(99) < 3)
                    send_point(1'b0, COORD_W'($urandom_range(4095)),
                               COORD_W'($urandom_range(4095)));
                x = int'(fit_coord(x + sx));
                y = int'(fit_coord(y + sy));
                send_point(1'b0, COORD_W'(x), COORD_W'(y));
            end
        end
    endtask

    // Main sequence.
    initial begin
        int          phase, noise;
        int unsigned angle, spacing, limit, phase_end;
        sb        = new();
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        i_valid   = 1'b0;
        i_first   = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_ready   = 1'b0;
        steady    = 1'b0;
        held_off  = 1'b0;
        hold_left = 0;
        settings_used = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset values of the registers.
        // Points before any seed continue from the origin.
        send_point(1'b0, 12'd100, 12'd0);
        send_point(1'b0, 12'd100, 12'd100);
        // Square at the coordinate extremes: vertical and horizontal edges,
        // a repeated point, and overflow after the fourth corner.
        send_point(1'b1, 12'd4095, 12'd4095);
        send_point(1'b0, 12'd4095, 12'd0);
        send_point(1'b0, 12'd0,    12'd0);
        send_point(1'b0, 12'd0,    12'd0);
        send_point(1'b0, 12'd0,    12'd4095);
        send_point(1'b0, 12'd4095, 12'd4095);
        send_point(1'b0, 12'd4095, 12'd0);
        send_point(1'b0, 12'd0,    12'd0);
        send_point(1'b0, 12'd0,    12'd4095);
        send_point(1'b0, 12'd1234, 12'd567);
        // Short diagonal edges: the distance test rejects close corners,
        // and a falling edge gives a negative direction.
        send_point(1'b1, 12'd2048, 12'd2048);
        send_point(1'b0, 12'd2050, 12'd2052);
        send_point(1'b0, 12'd2052, 12'd2053);
        send_point(1'b0, 12'd2053, 12'd2055);
        send_point(1'b0, 12'd2100, 12'd2055);
        send_point(1'b0, 12'd2100, 12'd2100);
        send_point(1'b0, 12'd2150, 12'd2050);
        send_point(1'b0, 12'd2200, 12'd2000);

        // Random part, one register setting per phase.
        for (phase = 0; phase < PHASES; phase++) begin
            drain_block();
            case (phase)
                0: begin angle = 4096;  spacing = 10;   limit = 4;   end
                1: begin angle = 0;     spacing = 0;    limit = 255; end
                2: begin angle = 1500;  spacing = 30;   limit = 16;  end
                3: begin angle = 32768; spacing = 8191; limit = 1;   end
                4: begin angle = 0;     spacing = 8191; limit = 255; end
                5: begin angle = 8000;  spacing = 0;    limit = 0;   end
                default: begin
                    angle   = $urandom_range(12000);
                    spacing = $urandom_range(200);
                    limit   = ($urandom_range(99) < 70) ? $urandom_range(12, 1)
                                                         : $urandom_range(255, 1);
                end
            endcase
            write_register(REG_ANGLE_THR, angle);
            write_register(REG_DIST_THR, spacing);
            write_register(REG_CORNER_LIMIT, limit);
            settings_used++;
            steady = (phase == STEADY_PHASE);
            phase_end = sb.points_seen + PHASE_ITEMS;
            while (sb.points_seen < phase_end) begin
                if ($urandom_range(99) < 85) begin
                    send_hull();
                end else begin
                    // Loose points with a random seed flag.
                    noise = $urandom_range(8, 3);
                    repeat (noise)
                        send_point(1'($urandom_range(1)), COORD_W'($urandom_range(4095)),
                                   COORD_W'($urandom_range(4095)));
                end
            end
        end
        steady = 1'b0;
        drain_block();

        if (sb.pending_count() != 0)
            $display("ERROR: %0d corner items never arrived", sb.pending_count());
        $display("Run covered %0d points in %0d hulls under %0d register settings.",
                 sb.points_seen, sb.hulls_seen, settings_used);
        $display("Checked %0d corners and %0d overflow items, with a %0d-cycle output hold-off.",
                 sb.corners_checked, sb.overflows_checked, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("PASS hull_corner_detector_core");
        end else begin
            $display("FAIL hull_corner_detector_core");
        end
        $finish;
    end

endmodule
